>>> rtl/core/lcd_frame_serializer_core_macros.svh
// ----------------------------------------------------------------------------
// lcd_frame_serializer_core_macros.svh
// Assertion helpers shared by the serializer RTL.
// ----------------------------------------------------------------------------
`ifndef LCD_FRAME_SERIALIZER_CORE_MACROS_SVH
`define LCD_FRAME_SERIALIZER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Types and constants shared by the LCD frame serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

    // Serial protocol bytes
    localparam logic [7:0] SYNC_CMD        = 8'hF8;
    localparam logic [7:0] SYNC_DATA       = 8'hFA;
    localparam logic [7:0] ADDR_BASE       = 8'h80;
    localparam logic [7:0] ADDR_BASE_LOWER = 8'h88;
    localparam logic [7:0] NIBBLE_MASK     = 8'hF0;

    // Geometry
    localparam int         BIR_W           = 4;
    localparam int         ROW_W           = 6;
    localparam int         ROWS_W          = 7;
    localparam logic [5:0] HALF_ROWS       = 6'd32;
    localparam logic [6:0] MAX_ROWS        = 7'd64;
    localparam logic [6:0] ROWS_RESET      = 7'd64;

    // Defaults for top-level parameters
    localparam int DEF_BYTES_PER_ROW = 16;
    localparam int DEF_QUEUE_DEPTH   = 2;

    // One classified pixel word, ready for expansion
    typedef struct packed {
        logic       has_addr;
        logic [7:0] row_cmd;
        logic [7:0] col_cmd;
        logic [7:0] pixel;
        logic       frame_end;
    } lfs_desc_t;

    // Which transfer of a word is being sent
    typedef enum logic [1:0] {
        XFER_ROW,
        XFER_COL,
        XFER_PIX
    } lfs_xfer_t;

    // Which byte of a transfer is being sent
    typedef enum logic [1:0] {
        PH_SYNC,
        PH_HIGH,
        PH_LOW
    } lfs_phase_t;

endpackage

`default_nettype wire

>>> rtl/core/lfs_front.sv
// ----------------------------------------------------------------------------
// lfs_front
// Accepts pixel words, tracks row and column, and builds address commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_front
    import lfs_pkg::*;
#(
    parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [ROWS_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    input  wire logic [7:0]        pixel_byte,
    input  wire logic              queue_full,
    output logic                   push,
    output lfs_desc_t              push_data
);

    logic [BIR_W-1:0]  byte_in_row_reg, byte_in_row_next;
    logic [ROW_W-1:0]  row_index_reg, row_index_next;
    logic [ROWS_W-1:0] rows_in_use_reg;
    logic [ROWS_W-1:0] rows_eff;
    logic [BIR_W:0]    bir_plus;
    logic [ROWS_W-1:0] row_plus;
    logic              row_end;
    logic              frame_end;
    logic [2:0]        col;

    // Accept whenever the queue has room
    assign push = in_valid && !queue_full;

    // Clamp the configured row count into range
    always_comb
    begin
        if (rows_in_use_reg == '0)
            rows_eff = ROWS_W'(1);
        else if (rows_in_use_reg > MAX_ROWS)
            rows_eff = MAX_ROWS;
        else
            rows_eff = rows_in_use_reg;
    end

    // Detect row and frame boundaries
    assign bir_plus  = {1'b0, byte_in_row_reg} + (BIR_W+1)'(1);
    assign row_plus  = {1'b0, row_index_reg} + ROWS_W'(1);
    assign row_end   = bir_plus >= (BIR_W+1)'(BYTES_PER_ROW);
    assign frame_end = row_end && (row_plus >= rows_eff);
    assign col       = byte_in_row_reg[BIR_W-1:1];

    // Build the word descriptor
    always_comb
    begin
        push_data.has_addr  = !byte_in_row_reg[0];
        push_data.row_cmd   = ADDR_BASE | {3'b000, row_index_reg[4:0]};
        push_data.col_cmd   = ((row_index_reg >= HALF_ROWS) ? ADDR_BASE_LOWER : ADDR_BASE)
                              | {5'b00000, col};
        push_data.pixel     = pixel_byte;
        push_data.frame_end = frame_end;
    end

    // Advance position counters
    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        row_index_next   = row_index_reg;
        if (push)
        begin
            if (row_end)
            begin
                byte_in_row_next = '0;
                if (frame_end)
                    row_index_next = '0;
                else
                    row_index_next = row_plus[ROW_W-1:0];
            end
            else
            begin
                byte_in_row_next = bir_plus[BIR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= '0;
            row_index_reg   <= '0;
            rows_in_use_reg <= ROWS_RESET;
        end
        else
        begin
            byte_in_row_reg <= byte_in_row_next;
            row_index_reg   <= row_index_next;
            if (cfg_wr_en)
                rows_in_use_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lfs_queue.sv
// ----------------------------------------------------------------------------
// lfs_queue
// Short register queue of word descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_queue
    import lfs_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire lfs_desc_t push_data,
    input  wire logic      pop,
    output logic           full,
    output logic           head_valid,
    output lfs_desc_t      head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfs_desc_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming descriptor
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> rtl/core/lfs_back.sv
// ----------------------------------------------------------------------------
// lfs_back
// Expands each descriptor into serial transfers behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_back
    import lfs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      head_valid,
    input  wire lfs_desc_t head_data,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output logic [7:0]     spi_byte,
    output logic           transfer_end,
    output logic           last_of_run,
    output logic           frame_done
);

    lfs_xfer_t  xfer_reg, xfer_next, cur_xfer;
    lfs_phase_t phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] spi_byte_reg;
    logic       transfer_end_reg, last_of_run_reg, frame_done_reg;
    logic       out_free, step;
    logic [7:0] value;
    logic [7:0] byte_gen;
    logic       end_gen, last_gen, frame_gen;

    // Skip the address transfers for odd words
    assign cur_xfer = (xfer_reg == XFER_ROW && !head_data.has_addr) ? XFER_PIX : xfer_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = head_valid && out_free;

    // Next state of the transfer sequencer
    always_comb
    begin
        xfer_next  = xfer_reg;
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                PH_SYNC: phase_next = PH_HIGH;
                PH_HIGH: phase_next = PH_LOW;
                default:
                begin
                    phase_next = PH_SYNC;
                    case (cur_xfer)
                        XFER_ROW: xfer_next = XFER_COL;
                        XFER_COL: xfer_next = XFER_PIX;
                        default:  xfer_next = XFER_ROW;
                    endcase
                end
            endcase
        end
    end

    // Sequencer outputs: the byte to send and its markers
    always_comb
    begin
        case (cur_xfer)
            XFER_ROW: value = head_data.row_cmd;
            XFER_COL: value = head_data.col_cmd;
            default:  value = head_data.pixel;
        endcase
        case (phase_reg)
            PH_SYNC: byte_gen = (cur_xfer == XFER_PIX) ? SYNC_DATA : SYNC_CMD;
            PH_HIGH: byte_gen = value & NIBBLE_MASK;
            PH_LOW:  byte_gen = {value[3:0], 4'b0000};
            default: byte_gen = '0;
        endcase
        end_gen   = phase_reg == PH_LOW;
        last_gen  = end_gen && cur_xfer == XFER_PIX;
        frame_gen = last_gen && head_data.frame_end;
        pop       = step && last_gen;
    end

    // Hold output until taken
    assign out_valid_next = step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_reg      <= XFER_ROW;
            phase_reg     <= PH_SYNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            xfer_reg      <= xfer_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            spi_byte_reg     <= byte_gen;
            transfer_end_reg <= end_gen;
            last_of_run_reg  <= last_gen;
            frame_done_reg   <= frame_gen;
        end
    end

    assign out_valid    = out_valid_reg;
    assign spi_byte     = spi_byte_reg;
    assign transfer_end = transfer_end_reg;
    assign last_of_run  = last_of_run_reg;
    assign frame_done   = frame_done_reg;

endmodule

`default_nettype wire

>>> rtl/core/lcd_frame_serializer_core.sv
// ----------------------------------------------------------------------------
// lcd_frame_serializer_core
// Turns frame-buffer words into the serial byte stream of a 128x64 LCD.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / pixel_byte) takes frame-buffer words
//   in row order, BYTES_PER_ROW words per row. Output channel (out_valid /
//   out_stall) gives serial bytes with transfer_end, last_of_run and
//   frame_done markers. cfg_wr_en / cfg_wr_data set the row count.
//   Each word at an even position expands to nine bytes (row address, column
//   address, data); a word at an odd position expands to three. The output
//   sequencer emits one byte per cycle while it holds a word and the output
//   is not stalled; a full row of 16 words gives 96 bytes.
//   When the block is empty, an accepted word goes first into the descriptor
//   queue and from there its first byte into the output register. A short
//   descriptor queue lets the front take new words while the back is still
//   expanding earlier ones.
//   Reset clears the row and column counters, empties the queue and sets the
//   row count to 64. When the receiver stalls, the output byte holds; once
//   the queue fills, in_stall rises until a word finishes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_frame_serializer_core_macros.svh"

module lcd_frame_serializer_core
    import lfs_pkg::*;
#(
    parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [ROWS_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        pixel_byte,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             spi_byte,
    output logic                   transfer_end,
    output logic                   last_of_run,
    output logic                   frame_done
);

    logic      push;
    lfs_desc_t push_data;
    logic      queue_full;
    logic      head_valid;
    lfs_desc_t head_data;
    logic      pop;

    assign in_stall = queue_full;

    // Classify incoming words
    lfs_front #(
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .pixel_byte  (pixel_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    // Buffer descriptors
    lfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Expand into serial bytes
    lfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .spi_byte     (spi_byte),
        .transfer_end (transfer_end),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    // Check marker consistency and back-to-back expansion
    `LFS_ASSERT_SAME(a_frame_on_last, clk, rst_n, out_valid && frame_done, last_of_run && transfer_end, "frame_done without last byte of word")
    `LFS_ASSERT_SAME(a_last_ends_xfer, clk, rst_n, out_valid && last_of_run, transfer_end, "last_of_run off a transfer end")
    `LFS_ASSERT_NEXT(a_word_continues, clk, rst_n, out_valid && !out_stall && !last_of_run, out_valid, "gap inside a word expansion")

endmodule

`default_nettype wire

>>> dv/lcd_frame_serializer_core_tb.sv
// ----------------------------------------------------------------------------
// lcd_frame_serializer_core_tb
// Self-checking bench for the LCD frame serializer. A queue-fed driver offers
// frame-buffer words and a clocked monitor compares every serial byte with
// the expansion worked out by an in-bench predictor of the address and
// counter logic. Both sides idle and stall at random. The row count is
// changed between phases, including zero, out of range and lowered mid-frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_frame_serializer_core_tb;
    import lfs_pkg::*;

    localparam int BYTES_PER_ROW  = DEF_BYTES_PER_ROW;
    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // One serial byte with its markers
    typedef struct packed {
        logic [7:0] spi;
        logic       xfer_end;
        logic       run_last;
        logic       frame_last;
    } serial_byte_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [ROWS_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        pixel_byte;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        spi_byte;
    logic              transfer_end;
    logic              last_of_run;
    logic              frame_done;

    // Predictor state: position in row, row, and row-count register
    logic [BIR_W-1:0]  line_pos;
    logic [ROW_W-1:0]  line_row;
    logic [ROWS_W-1:0] rows_setting;

    serial_byte_t      serial_expect_q[$];
    logic [7:0]        word_pending_q[$];
    logic [7:0]        cur_word;
    bit                word_offered;

    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                rx_hold_req;
    int                rx_hold_left;

    int                error_count;
    int                words_sent;
    int                bytes_checked;
    int                frames_seen;
    int                in_stall_cycles;
    int                quiet_cycles;

    serial_byte_t      seen_byte;
    serial_byte_t      want_byte;

    lcd_frame_serializer_core #(
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_byte   (pixel_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .spi_byte     (spi_byte),
        .transfer_end (transfer_end),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Count a failure, report only the first few
    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // Queue one three-byte transfer: sync, high nibble, low nibble moved up
    function automatic void queue_transfer(logic [7:0] sync, logic [7:0] value);
        serial_byte_t b;
        b = '{spi: sync, xfer_end: 1'b0, run_last: 1'b0, frame_last: 1'b0};
        serial_expect_q.push_back(b);
        b.spi = value & NIBBLE_MASK;
        serial_expect_q.push_back(b);
        b.spi      = {value[3:0], 4'h0};
        b.xfer_end = 1'b1;
        serial_expect_q.push_back(b);
    endfunction

    // Expand one accepted word and advance the row and column counters
    function automatic void expand_word(logic [7:0] pix);
        logic [ROWS_W-1:0] rows;
        logic [7:0]        base;
        logic              frame_end;
        serial_byte_t      tail;
        rows = rows_setting;
        if (rows == '0)
        begin
            rows = 7'd1;
        end
        if (rows > MAX_ROWS)
        begin
            rows = MAX_ROWS;
        end

        // Even position: row and column address commands first
        if (!line_pos[0])
        begin
            base = (line_row >= HALF_ROWS) ? ADDR_BASE_LOWER : ADDR_BASE;
            queue_transfer(SYNC_CMD, ADDR_BASE | {3'b000, line_row[4:0]});
            queue_transfer(SYNC_CMD, base | {5'b00000, line_pos[3:1]});
        end
        queue_transfer(SYNC_DATA, pix);

        // Advance position, wrap row and frame
        frame_end = 1'b0;
        if (int'(line_pos) + 1 >= BYTES_PER_ROW)
        begin
            line_pos = '0;
            if (int'(line_row) + 1 >= int'(rows))
            begin
                line_row  = '0;
                frame_end = 1'b1;
            end
            else
            begin
                line_row = line_row + 1'b1;
            end
        end
        else
        begin
            line_pos = line_pos + 1'b1;
        end

        // Mark the tail of this word
        tail            = serial_expect_q[serial_expect_q.size() - 1];
        tail.run_last   = 1'b1;
        tail.frame_last = frame_end;
        serial_expect_q[serial_expect_q.size() - 1] = tail;
    endfunction

    // Driver: offer the next pending word, hold it while stalled
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!word_offered)
        begin
            if (word_pending_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                cur_word     = word_pending_q.pop_front();
                pixel_byte   <= cur_word;
                in_valid     <= 1'b1;
                word_offered = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Driver: predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_valid)
        begin
            if (!in_stall)
            begin
                expand_word(cur_word);
                word_offered = 1'b0;
                words_sent++;
            end
            else
            begin
                in_stall_cycles++;
            end
        end
    end

    // Receiver: random stall, or a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            out_stall    <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end
        else if (rx_hold_req)
        begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES - 1;
            out_stall    <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Monitor: compare each accepted byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_byte = '{spi: spi_byte, xfer_end: transfer_end,
                          run_last: last_of_run, frame_last: frame_done};
            bytes_checked++;
            if (frame_done)
            begin
                frames_seen++;
            end
            if (serial_expect_q.size() == 0)
            begin
                note_error($sformatf("unexpected byte %h end=%b last=%b frame=%b",
                    spi_byte, transfer_end, last_of_run, frame_done));
            end
            else
            begin
                want_byte = serial_expect_q.pop_front();
                if (seen_byte !== want_byte)
                begin
                    note_error($sformatf(
                        "byte %0d: exp %h/%b/%b/%b got %h/%b/%b/%b (byte/end/last/frame)",
                        bytes_checked, want_byte.spi, want_byte.xfer_end,
                        want_byte.run_last, want_byte.frame_last, seen_byte.spi,
                        seen_byte.xfer_end, seen_byte.run_last, seen_byte.frame_last));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("ERROR: no handshake for %0d cycles, %0d bytes still expected",
                        quiet_cycles, serial_expect_q.size());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Wait until every word is taken and every byte has come out
    task automatic wait_drained();
        while (word_pending_q.size() != 0 || word_offered || serial_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write the row count while the block is idle
    task automatic write_rows(logic [ROWS_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        rows_setting = value;
        @(posedge clk);
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
        begin
            word_pending_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        pixel_byte   = '0;
        out_stall    = 1'b0;
        line_pos     = '0;
        line_row     = '0;
        rows_setting = ROWS_RESET;
        word_offered = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_req  = 1'b0;
        rx_hold_left = 0;
        error_count  = 0;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: nibble extremes at the reset row count
        word_pending_q.push_back(8'h00);
        word_pending_q.push_back(8'hFF);
        word_pending_q.push_back(8'h0F);
        word_pending_q.push_back(8'hF0);

        // Zero row count acts as one row: frame ends with this row
        write_rows(7'd0);
        word_pending_q.push_back(8'h80);
        word_pending_q.push_back(8'h01);
        word_pending_q.push_back(8'h7F);
        word_pending_q.push_back(8'hFE);
        word_pending_q.push_back(8'h55);
        word_pending_q.push_back(8'hAA);
        push_random(6);

        // Row count above range clamps to the full panel
        write_rows(7'd127);
        push_random(8);

        // Short frames, slow receiver
        write_rows(7'd3);
        tx_idle_pct = 23;
        rx_idle_pct = 84;
        push_random(100);

        // Full row count, slow sender; pause mid-phase until all bytes are out
        write_rows(7'd64);
        tx_idle_pct = 84;
        rx_idle_pct = 23;
        push_random(50);
        wait_drained();
        push_random(50);

        // No idling, with a long receiver hold-off
        write_rows(7'd40);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random(40);
        rx_hold_req = 1'b1;

        // Lower the row count to end at the current row: frame ends with this row
        write_rows(7'd3);
        push_random(24);

        write_rows(7'd1);
        push_random(16);

        write_rows(7'd2);
        tx_idle_pct = 23;
        rx_idle_pct = 23;
        push_random(20);

        // Drain and let any stray byte show up
        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("Run covered %0d words and %0d serial bytes, %0d frame ends,",
            words_sent, bytes_checked, frames_seen);
        $display("row counts 0/1/2/3/40/64/127, a lowered row count, %0d input stall cycles.",
            in_stall_cycles);
        if (error_count == 0 && serial_expect_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches, %0d bytes left", error_count, serial_expect_q.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
